// ===== sv/cttu_pkg.sv =====
`timescale 1ns / 1ps
package cttu_pkg;

    // Fixed field widths of the ports
    localparam int INDEX_BITS    = 12;
    localparam int TIME_BITS     = 32;
    localparam int FRAC_OUT_BITS = 18;
    localparam int FRAC_OUT_F    = 16;
    localparam int PERIOD_BITS   = 16;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 16'd2000;

    // Newton step magnitude is capped at 2^DIV_INT_BITS
    localparam int DIV_INT_BITS = 3;
    // cubic coefficients (times 6) grow this many bits over a sample
    localparam int COEF_GUARD   = 4;
    // headroom of residual and slope over sample plus fraction bits
    localparam int WIDE_GUARD   = 10;

    typedef logic [INDEX_BITS-1:0] index_t;

endpackage

// ===== sv/cttu_div.sv =====
`timescale 1ns / 1ps
module cttu_div #(
    parameter int WW   = 42,
    parameter int F    = 16,
    parameter int CTXW = 1,
    localparam int QB  = F + cttu_pkg::DIV_INT_BITS,
    localparam int QW  = QB + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [WW-1:0] num,
    input  logic signed [WW-1:0] den,
    input  logic [CTXW-1:0]      ctx_in,
    output logic                 out_valid,
    output logic signed [QW-1:0] quo,
    output logic                 zero,
    output logic [CTXW-1:0]      ctx_out
);

    localparam int RW = WW + cttu_pkg::DIV_INT_BITS + 1;

    logic [QB:0]     v_reg;
    logic            neg_reg  [QB+1];
    logic            cap_reg  [QB+1];
    logic            zero_reg [QB+1];
    logic [RW-1:0]   rem_reg  [QB+1];
    logic [RW-1:0]   dv_reg   [QB+1];
    logic [QB-1:0]   q_reg    [QB+1];
    logic [CTXW-1:0] ctx_reg  [QB+1];

    logic [WW-1:0] un;
    logic [WW-1:0] ud;
    logic [RW-1:0] ud8;
    logic [QW-1:0] mag;

    // magnitudes; divisor pre-scaled by 2^DIV_INT_BITS
    always_comb
    begin
        un  = num[WW-1] ? WW'(-num) : num;
        ud  = den[WW-1] ? WW'(-den) : den;
        ud8 = RW'({ud, {cttu_pkg::DIV_INT_BITS{1'b0}}});
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[QB-1:0], in_valid};
        end
    end

    // setup stage: signs, cap test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0]  <= num[WW-1] ^ den[WW-1];
            cap_reg[0]  <= RW'(un) >= ud8;
            zero_reg[0] <= (den == '0);
            rem_reg[0]  <= RW'(un);
            dv_reg[0]   <= ud8;
            q_reg[0]    <= '0;
            ctx_reg[0]  <= ctx_in;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar j = 1; j <= QB; j++)
    begin : g_bit
        logic [RW-1:0] dbl;
        logic          take;

        assign dbl  = {rem_reg[j-1][RW-2:0], 1'b0};
        assign take = dbl >= dv_reg[j-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= take ? dbl - dv_reg[j-1] : dbl;
                q_reg[j]    <= {q_reg[j-1][QB-2:0], take};
                dv_reg[j]   <= dv_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                cap_reg[j]  <= cap_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                ctx_reg[j]  <= ctx_reg[j-1];
            end
        end
    end

    // capped magnitude, then sign
    assign mag       = cap_reg[QB] ? {2'b01, {QB{1'b0}}} : {2'b00, q_reg[QB]};
    assign quo       = neg_reg[QB] ? -$signed(mag) : $signed(mag);
    assign out_valid = v_reg[QB];
    assign zero      = zero_reg[QB];
    assign ctx_out   = ctx_reg[QB];

endmodule

// ===== sv/cttu_step.sv =====
`timescale 1ns / 1ps
module cttu_step #(
    parameter int SB  = 16,
    parameter int F   = 16,
    localparam int CW = SB + cttu_pkg::COEF_GUARD,
    localparam int XW = F + 2,
    localparam int LW = SB + 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  c3_in,
    input  logic signed [CW-1:0]  c2_in,
    input  logic signed [CW-1:0]  c1_in,
    input  logic signed [LW-1:0]  lvb_in,
    input  cttu_pkg::index_t      ci_in,
    input  logic signed [XW-1:0]  x_in,
    input  logic                  err_in,
    output logic                  out_valid,
    output logic signed [CW-1:0]  c3_out,
    output logic signed [CW-1:0]  c2_out,
    output logic signed [CW-1:0]  c1_out,
    output logic signed [LW-1:0]  lvb_out,
    output cttu_pkg::index_t      ci_out,
    output logic signed [XW-1:0]  x_out,
    output logic                  err_out
);

    localparam int WW = SB + F + cttu_pkg::WIDE_GUARD;
    localparam int QW = F + cttu_pkg::DIV_INT_BITS + 2;

    localparam logic signed [QW:0] SUM_MAX = (QW+1)'((1 << (F+1)) - 1);
    localparam logic signed [QW:0] SUM_MIN = (QW+1)'(-(1 << (F+1)));
    localparam logic [XW-1:0] XMAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] XMIN = {1'b1, {(XW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] c3;
        logic signed [CW-1:0] c2;
        logic signed [CW-1:0] c1;
        logic signed [LW-1:0] lvb;
        cttu_pkg::index_t     ci;
        logic signed [XW-1:0] x;
        logic                 err;
    } item_t;

    localparam int CTXW = $bits(item_t) + 2;

    item_t it_in;
    item_t s1_it_reg, s2_it_reg, s3_it_reg, o_it_reg;
    logic  s1_v_reg, s2_v_reg, s3_v_reg, o_v_reg;

    logic signed [WW-1:0] s1_h_reg, s1_d_reg, s2_h_reg, s2_d_reg, s3_r_reg, s3_d_reg;
    logic signed [WW-1:0] s1_h_next, s1_d_next, s2_h_next, s2_d_next, s3_r_next;

    logic signed [CW+XW-1:0] m3;
    logic signed [WW+XW-1:0] mh2, md2, mh3;
    logic signed [SB+3:0]    lvbx, lvb6;

    logic                 div_v, div_zero;
    logic signed [QW-1:0] div_quo;
    logic [CTXW-1:0]      div_ctx;
    item_t                it_d, o_it_next;
    logic                 r_pos, r_neg;
    logic signed [QW:0]   sum;

    assign it_in = '{c3: c3_in, c2: c2_in, c1: c1_in, lvb: lvb_in,
                     ci: ci_in, x: x_in, err: err_in};

    // stage 1: c3*x, first Horner terms
    always_comb
    begin
        m3        = it_in.c3 * it_in.x;
        s1_h_next = WW'(m3) + (WW'(it_in.c2) <<< F);
        s1_d_next = WW'(m3) + (WW'(m3) <<< 1) + (WW'(it_in.c2) <<< (F+1));
    end

    // stage 2: second Horner products, slope done
    always_comb
    begin
        mh2       = s1_h_reg * s1_it_reg.x;
        md2       = s1_d_reg * s1_it_reg.x;
        s2_h_next = WW'(mh2 >>> F) + (WW'(s1_it_reg.c1) <<< F);
        s2_d_next = WW'(md2 >>> F) + (WW'(s1_it_reg.c1) <<< F);
    end

    // stage 3: last product, residual against 6*level
    always_comb
    begin
        mh3       = s2_h_reg * s2_it_reg.x;
        lvbx      = (SB+4)'(s2_it_reg.lvb);
        lvb6      = (lvbx <<< 2) + (lvbx <<< 1);
        s3_r_next = (WW'(lvb6) <<< F) - WW'(mh3 >>> F);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            o_v_reg  <= div_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_it_reg <= it_in;
            s1_h_reg  <= s1_h_next;
            s1_d_reg  <= s1_d_next;
            s2_it_reg <= s1_it_reg;
            s2_h_reg  <= s2_h_next;
            s2_d_reg  <= s2_d_next;
            s3_it_reg <= s2_it_reg;
            s3_r_reg  <= s3_r_next;
            s3_d_reg  <= s2_d_reg;
            o_it_reg  <= o_it_next;
        end
    end

    // residual / slope
    cttu_div #(
        .WW   (WW),
        .F    (F),
        .CTXW (CTXW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_v_reg),
        .num       (s3_r_reg),
        .den       (s3_d_reg),
        .ctx_in    ({s3_it_reg, (!s3_r_reg[WW-1] && (s3_r_reg != '0)), s3_r_reg[WW-1]}),
        .out_valid (div_v),
        .quo       (div_quo),
        .zero      (div_zero),
        .ctx_out   (div_ctx)
    );

    // update x; flat slope saturates by residual sign and stops the item
    always_comb
    begin
        it_d      = div_ctx[CTXW-1:2];
        r_pos     = div_ctx[1];
        r_neg     = div_ctx[0];
        sum       = (QW+1)'(it_d.x) + (QW+1)'(div_quo);
        o_it_next = it_d;
        if (!it_d.err)
        begin
            if (div_zero)
            begin
                o_it_next.err = 1'b1;
                if (r_pos)
                begin
                    o_it_next.x = XMAX;
                end
                else if (r_neg)
                begin
                    o_it_next.x = XMIN;
                end
            end
            else if (sum > SUM_MAX)
            begin
                o_it_next.x = XMAX;
            end
            else if (sum < SUM_MIN)
            begin
                o_it_next.x = XMIN;
            end
            else
            begin
                o_it_next.x = sum[XW-1:0];
            end
        end
    end

    assign out_valid = o_v_reg;
    assign c3_out    = o_it_reg.c3;
    assign c2_out    = o_it_reg.c2;
    assign c1_out    = o_it_reg.c1;
    assign lvb_out   = o_it_reg.lvb;
    assign ci_out    = o_it_reg.ci;
    assign x_out     = o_it_reg.x;
    assign err_out   = o_it_reg.err;

endmodule

// ===== sv/cubic_threshold_crossing_time_unit.sv =====
`timescale 1ns / 1ps
// Cubic threshold crossing time.
// Input channel (in_valid/in_ready): four samples around a rising crossing,
// the level and the index of the first sample above it. Output channel
// (out_valid/out_ready): crossing time in ps, fraction (Q1.16), flat flag.
// Config channel (cfg_valid/cfg_ready/cfg_data): sample period in ps,
// always ready, write only while the block is idle.
// Throughput: one item per cycle while not stalled. An item passes the
// input register, the first-guess divider, the guess register, the Newton
// steps, the position register and the output register. Each of the six
// divisions (first guess and one per Newton step) is a restoring divider
// with one quotient bit per stage, F + 3 bits long, F = FRACTION_BITS;
// each Newton step adds three multiply stages and one update stage.
// Reset clears all valid bits and loads the period with 2000 ps.
// The whole pipeline shares one enable: when a result waits and out_ready
// is low, every stage holds and in_ready drops; nothing is lost.
module cubic_threshold_crossing_time_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 16,
    parameter int NEWTON_STEPS  = 5
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_BITS-1:0]          sample_prev,
    input  logic signed [SAMPLE_BITS-1:0]          sample_below,
    input  logic signed [SAMPLE_BITS-1:0]          sample_above,
    input  logic signed [SAMPLE_BITS-1:0]          sample_next,
    input  logic signed [SAMPLE_BITS-1:0]          level,
    input  logic [cttu_pkg::INDEX_BITS-1:0]        cross_index,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [cttu_pkg::TIME_BITS-1:0]  crossing_time,
    output logic signed [cttu_pkg::FRAC_OUT_BITS-1:0] crossing_fraction,
    output logic                                   flat_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cttu_pkg::PERIOD_BITS-1:0]       cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int NS = NEWTON_STEPS;
    localparam int CW = SB + cttu_pkg::COEF_GUARD;
    localparam int XW = F + 2;
    localparam int LW = SB + 1;
    localparam int WW = SB + F + cttu_pkg::WIDE_GUARD;
    localparam int QW = F + cttu_pkg::DIV_INT_BITS + 2;
    localparam int PW = cttu_pkg::INDEX_BITS + 2 + F;
    localparam int MW = cttu_pkg::PERIOD_BITS + 1 + PW;

    localparam logic signed [QW-1:0] QMAX = QW'((1 << (F+1)) - 1);
    localparam logic signed [QW-1:0] QMIN = QW'(-(1 << (F+1)));
    localparam logic [XW-1:0] XMAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] XMIN = {1'b1, {(XW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] c3;
        logic signed [CW-1:0] c2;
        logic signed [CW-1:0] c1;
        logic signed [LW-1:0] lvb;
        cttu_pkg::index_t     ci;
        logic signed [XW-1:0] x;
        logic                 err;
    } item_t;

    localparam int CTXW = $bits(item_t);

    logic en;

    logic [cttu_pkg::PERIOD_BITS-1:0] sample_period_reg;

    logic signed [CW-1:0] vp, vb, va, vn;
    item_t                p_it_next, p_it_reg;
    logic signed [LW-1:0] p_den_next, p_den_reg;
    logic                 p_v_reg;

    logic                 div_v, div_zero;
    logic signed [QW-1:0] div_quo;
    logic [CTXW-1:0]      div_ctx;
    item_t                it_d, init_it_next, init_it_reg;
    logic                 init_v_reg;

    logic                 st_v   [NS+1];
    logic signed [CW-1:0] st_c3  [NS+1];
    logic signed [CW-1:0] st_c2  [NS+1];
    logic signed [CW-1:0] st_c1  [NS+1];
    logic signed [LW-1:0] st_lvb [NS+1];
    cttu_pkg::index_t     st_ci  [NS+1];
    logic signed [XW-1:0] st_x   [NS+1];
    logic                 st_err [NS+1];

    logic signed [PW-1:0] ci_s, pos_next, pos_reg;
    logic signed [cttu_pkg::FRAC_OUT_BITS-1:0] frac_next, frac_reg;
    logic                 err_reg, t1_v_reg;
    logic signed [MW-1:0] prod;

    logic                                      out_valid_reg;
    logic signed [cttu_pkg::TIME_BITS-1:0]     time_reg;
    logic signed [cttu_pkg::FRAC_OUT_BITS-1:0] frac_o_reg;
    logic                                      err_o_reg;

    // global advance: output register free or being taken
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= cttu_pkg::PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sample_period_reg <= cfg_data;
        end
    end

    // cubic coefficients times 6, level offset, linear guess operands
    always_comb
    begin
        vp = CW'(sample_prev);
        vb = CW'(sample_below);
        va = CW'(sample_above);
        vn = CW'(sample_next);
        p_it_next.c3  = (vb <<< 1) + vb - vp + vn - ((va <<< 1) + va);
        p_it_next.c2  = (va <<< 1) + va + (vp <<< 1) + vp - ((vb <<< 2) + (vb <<< 1));
        p_it_next.c1  = (va <<< 2) + (va <<< 1) - ((vb <<< 1) + vb) - vn - (vp <<< 1);
        p_it_next.lvb = LW'(level) - LW'(sample_below);
        p_it_next.ci  = cross_index;
        p_it_next.x   = '0;
        p_it_next.err = 1'b0;
        p_den_next    = LW'(sample_above) - LW'(sample_below);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg       <= 1'b0;
            init_v_reg    <= 1'b0;
            t1_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg       <= in_valid;
            init_v_reg    <= div_v;
            t1_v_reg      <= st_v[NS];
            out_valid_reg <= t1_v_reg;
        end
    end

    // first guess: (level - below) / (above - below)
    cttu_div #(
        .WW   (WW),
        .F    (F),
        .CTXW (CTXW)
    ) u_guess_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_v_reg),
        .num       (WW'(p_it_reg.lvb)),
        .den       (WW'(p_den_reg)),
        .ctx_in    (p_it_reg),
        .out_valid (div_v),
        .quo       (div_quo),
        .zero      (div_zero),
        .ctx_out   (div_ctx)
    );

    // flat guess saturates by level side; otherwise clamp
    always_comb
    begin
        it_d         = div_ctx;
        init_it_next = it_d;
        if (div_zero)
        begin
            init_it_next.err = 1'b1;
            if (!it_d.lvb[LW-1] && (it_d.lvb != '0))
            begin
                init_it_next.x = XMAX;
            end
            else if (it_d.lvb[LW-1])
            begin
                init_it_next.x = XMIN;
            end
            else
            begin
                init_it_next.x = '0;
            end
        end
        else if (div_quo > QMAX)
        begin
            init_it_next.x = XMAX;
        end
        else if (div_quo < QMIN)
        begin
            init_it_next.x = XMIN;
        end
        else
        begin
            init_it_next.x = div_quo[XW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_it_reg    <= p_it_next;
            p_den_reg   <= p_den_next;
            init_it_reg <= init_it_next;
            pos_reg     <= pos_next;
            frac_reg    <= frac_next;
            err_reg     <= st_err[NS];
            time_reg    <= cttu_pkg::TIME_BITS'(prod >>> F);
            frac_o_reg  <= frac_reg;
            err_o_reg   <= err_reg;
        end
    end

    // Newton chain
    assign st_v[0]   = init_v_reg;
    assign st_c3[0]  = init_it_reg.c3;
    assign st_c2[0]  = init_it_reg.c2;
    assign st_c1[0]  = init_it_reg.c1;
    assign st_lvb[0] = init_it_reg.lvb;
    assign st_ci[0]  = init_it_reg.ci;
    assign st_x[0]   = init_it_reg.x;
    assign st_err[0] = init_it_reg.err;

    for (genvar i = 0; i < NS; i++)
    begin : g_newton
        cttu_step #(
            .SB (SB),
            .F  (F)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (st_v[i]),
            .c3_in     (st_c3[i]),
            .c2_in     (st_c2[i]),
            .c1_in     (st_c1[i]),
            .lvb_in    (st_lvb[i]),
            .ci_in     (st_ci[i]),
            .x_in      (st_x[i]),
            .err_in    (st_err[i]),
            .out_valid (st_v[i+1]),
            .c3_out    (st_c3[i+1]),
            .c2_out    (st_c2[i+1]),
            .c1_out    (st_c1[i+1]),
            .lvb_out   (st_lvb[i+1]),
            .ci_out    (st_ci[i+1]),
            .x_out     (st_x[i+1]),
            .err_out   (st_err[i+1])
        );
    end

    // position in samples, Q.F
    always_comb
    begin
        ci_s     = PW'($signed({1'b0, st_ci[NS]}));
        pos_next = ((ci_s - PW'(1)) <<< F) + PW'(st_x[NS]);
    end

    // fraction rescaled to 16 fraction bits, floor when narrowing
    if (F >= cttu_pkg::FRAC_OUT_F)
    begin : g_frac_down
        assign frac_next = cttu_pkg::FRAC_OUT_BITS'(st_x[NS] >>> (F - cttu_pkg::FRAC_OUT_F));
    end
    else
    begin : g_frac_up
        assign frac_next = cttu_pkg::FRAC_OUT_BITS'(st_x[NS]) <<< (cttu_pkg::FRAC_OUT_F - F);
    end

    // time = period * position, floored
    assign prod = $signed({1'b0, sample_period_reg}) * pos_reg;

    assign out_valid         = out_valid_reg;
    assign crossing_time     = time_reg;
    assign crossing_fraction = frac_o_reg;
    assign flat_error        = err_o_reg;

    // stalled pipeline holds its last stages
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pos_reg) && $stable(t1_v_reg))
        else $error("pipeline moved while stalled");

    // flat first guess always flags the item
    a_flat_guess: assert property (@(posedge clk) disable iff (!rst_n)
        en && div_v && div_zero |=> init_it_reg.err)
        else $error("flat first guess not flagged");

    // period changes only on a config write
    a_period_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_valid && cfg_ready) |=> $stable(sample_period_reg))
        else $error("sample period changed without a write");

endmodule

// ===== tb/cubic_threshold_crossing_time_unit_tb.sv =====
`timescale 1ns / 1ps
module cubic_threshold_crossing_time_unit_tb;

    localparam int FB = 16;
    localparam longint FONE = 64'sd1 << FB;
    localparam longint XMAX = 2 * FONE - 1;
    localparam longint XMIN = -2 * FONE;
    localparam longint STEP_CAP = 8 * FONE;
    localparam int LATENCY = 144;

    typedef struct packed {
        logic signed [15:0] prev;
        logic signed [15:0] below;
        logic signed [15:0] above;
        logic signed [15:0] nxt;
        logic signed [15:0] lvl;
        cttu_pkg::index_t   idx;
    } crossing_item_t;

    typedef struct packed {
        logic signed [cttu_pkg::TIME_BITS-1:0]     t;
        logic signed [cttu_pkg::FRAC_OUT_BITS-1:0] frac;
        logic                                      flat;
    } crossing_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] sample_prev = '0, sample_below = '0, sample_above = '0;
    logic signed [15:0] sample_next = '0, level = '0;
    cttu_pkg::index_t cross_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [cttu_pkg::TIME_BITS-1:0] crossing_time;
    logic signed [cttu_pkg::FRAC_OUT_BITS-1:0] crossing_fraction;
    logic flat_error;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [cttu_pkg::PERIOD_BITS-1:0] cfg_data = '0;

    crossing_item_t   pending_items[$];
    crossing_result_t expected_results[$];
    logic [cttu_pkg::PERIOD_BITS-1:0] period_ps = cttu_pkg::PERIOD_RESET;
    logic [15:0] periods[4] = '{16'd0, 16'd65535, 16'd1, 16'd12345};
    logic in_taken = 1'b0;
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_flat = 0;

    always #4 clk = ~clk;

    cubic_threshold_crossing_time_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_prev(sample_prev), .sample_below(sample_below),
        .sample_above(sample_above), .sample_next(sample_next),
        .level(level), .cross_index(cross_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .crossing_time(crossing_time), .crossing_fraction(crossing_fraction),
        .flat_error(flat_error),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // floor(v / 2^k)
    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    // floor(h * x / 2^FB) without overflow
    function automatic longint fmul(longint h, longint x);
        longint hh;
        longint hl;
        hh = h >>> FB;
        hl = h - hh * FONE;
        return hh * x + ((hl * x) >>> FB);
    endfunction

    // n / d in Q.FB, truncated toward zero, magnitude capped
    function automatic longint fdiv(longint n, longint d);
        logic neg;
        longint un;
        longint ud;
        longint q;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        if (un / ud >= 8) q = STEP_CAP;
        else q = (un * FONE) / ud;
        return neg ? -q : q;
    endfunction

    function automatic longint clamp_pos(longint x);
        if (x > XMAX) return XMAX;
        if (x < XMIN) return XMIN;
        return x;
    endfunction

    // Linear guess refined by Newton steps on the cubic through the samples
    function automatic crossing_result_t crossing_of(crossing_item_t it,
                                                     logic [15:0] per);
        crossing_result_t r;
        longint p, b, a, nx, lv, c3, c2, c1, l6, x, h, res, d;
        logic flat;
        p = longint'(it.prev);
        b = longint'(it.below);
        a = longint'(it.above);
        nx = longint'(it.nxt);
        lv = longint'(it.lvl);
        c3 = (3 * b - p + nx - 3 * a) * FONE;
        c2 = (3 * a + 3 * p - 6 * b) * FONE;
        c1 = (6 * a - 3 * b - nx - 2 * p) * FONE;
        l6 = 6 * (lv - b) * FONE;
        flat = 1'b0;
        if (a == b)
        begin
            flat = 1'b1;
            x = lv > b ? XMAX : (lv < b ? XMIN : 0);
        end
        else x = clamp_pos(fdiv(lv - b, a - b));
        for (int k = 0; k < 5 && !flat; k++)
        begin
            h = fmul(fmul(fmul(c3, x) + c2, x) + c1, x);
            res = l6 - h;
            d = fmul(fmul(3 * c3, x) + 2 * c2, x) + c1;
            if (d == 0)
            begin
                flat = 1'b1;
                if (res > 0) x = XMAX;
                else if (res < 0) x = XMIN;
            end
            else x = clamp_pos(x + fdiv(res, d));
        end
        r.t = cttu_pkg::TIME_BITS'(floor_shift(longint'(per)
                  * ((longint'(it.idx) - 1) * FONE + x), FB));
        r.frac = cttu_pkg::FRAC_OUT_BITS'(x);
        r.flat = flat;
        return r;
    endfunction

    // Input monitor: record each item accepted at this edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expected_results.push_back(crossing_of({sample_prev, sample_below,
                sample_above, sample_next, level, cross_index}, period_ps));
            n_items++;
        end
    end

    // Driver: present the next item at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= in_gap_pct)
                begin
                    crossing_item_t it;
                    it = pending_items.pop_front();
                    {sample_prev, sample_below, sample_above, sample_next, level,
                     cross_index} = it;
                    in_valid <= 1'b1;
                end
                else in_valid <= 1'b0;
            end
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            crossing_result_t e;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result t=%0d frac=%0d flat=%0b", $time,
                         crossing_time, crossing_fraction, flat_error);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                n_results++;
                if (e.flat) n_flat++;
                if (crossing_time !== e.t)
                begin
                    $display("%0t: crossing_time expected %0d actual %0d", $time,
                             e.t, crossing_time);
                    errors++;
                end
                if (crossing_fraction !== e.frac)
                begin
                    $display("%0t: crossing_fraction expected %0d actual %0d", $time,
                             e.frac, crossing_fraction);
                    errors++;
                end
                if (flat_error !== e.flat)
                begin
                    $display("%0t: flat_error expected %0b actual %0b", $time,
                             e.flat, flat_error);
                    errors++;
                end
            end
        end
    end

    function automatic crossing_item_t rand_item();
        crossing_item_t it;
        int b, s1, s2, s3;
        it.idx = cttu_pkg::index_t'($urandom_range(4094, 2));
        case ($urandom_range(9))
            0: it = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), it.idx};
            1:
            begin
                // flat pair around the level
                it = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), it.idx};
                it.above = it.below;
                if ($urandom_range(1)) it.lvl = it.below;
            end
            default:
            begin
                // well-formed rising crossing
                b = int'($urandom_range(60000)) - 30000;
                s1 = int'($urandom_range(2000));
                s2 = int'($urandom_range(2000));
                s3 = int'($urandom_range(2000));
                it.below = 16'(b);
                it.above = 16'(b + 1 + int'($urandom_range(2700)));
                it.prev = 16'(b - s1 + 1000);
                it.nxt = 16'(int'(it.above) + s2 - 1000);
                it.lvl = 16'(b + int'($urandom_range(32'(int'(it.above) - b - 1))));
                if (s3 < 100) it.idx = cttu_pkg::index_t'($urandom_range(3));
            end
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_period(logic [15:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        period_ps = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, flat guess, flat slope, small index
        pending_items.push_back({16'sd0, 16'sd0, 16'sd100, 16'sd200, 16'sd50, 12'd2});
        pending_items.push_back({-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                                 16'sd0, 12'd4094});
        pending_items.push_back({16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                                 16'sd32767, 12'd4095});
        pending_items.push_back({16'sd5, 16'sd10, 16'sd10, 16'sd20, 16'sd20, 12'd5});
        pending_items.push_back({16'sd5, 16'sd10, 16'sd10, 16'sd20, -16'sd5, 12'd5});
        pending_items.push_back({16'sd5, 16'sd10, 16'sd10, 16'sd20, 16'sd10, 12'd5});
        pending_items.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 12'd0});
        pending_items.push_back({16'sd0, 16'sd0, 16'sd6, 16'sd0, 16'sd3, 12'd1});
        pending_items.push_back({-16'sd3, 16'sd0, 16'sd3, 16'sd6, 16'sd1, 12'd0});
        pending_items.push_back({16'sd100, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 12'd7});
        pending_items.push_back({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 12'd3});
        pending_items.push_back({16'sd0, 16'sd100, -16'sd100, 16'sd0, -16'sd32768,
                                 12'hFFF});
        pending_items.push_back({-16'sd1, 16'sd32767, -16'sd32768, 16'sd0,
                                 16'sd32767, 12'hAAA});
        pending_items.push_back({16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                                 16'sh5555, 12'h555});
        wait_drained();

        // Random phases across register settings and idling patterns
        for (int ph = 0; ph < 4; ph++)
        begin
            write_period(periods[ph]);
            case (ph)
                0:
                begin
                    in_gap_pct = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_gap_pct = 88;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_gap_pct = 0;
                    out_stall_pct = 88;
                end
                default:
                begin
                    in_gap_pct = 10;
                    out_stall_pct = 10;
                end
            endcase
            for (int i = 0; i < 100; i++) pending_items.push_back(rand_item());
            wait_drained();
        end

        $display("Covered %0d items, %0d results (%0d flat), periods 0 to 65535,",
                 n_items, n_results, n_flat);
        $display("with sender gaps and receiver stalls in separate phases.");
        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
